FILE: sv/ssp_pkg.sv
// Shared types, constants and helpers of the stencil sparsity pattern generator.
`default_nettype none

package ssp_pkg;

    localparam int EXT_BITS  = 10;
    localparam int EXT_W     = EXT_BITS + 1;
    localparam int PLANE_W   = 2 * EXT_BITS + 1;
    localparam int TOT_W     = 3 * EXT_BITS + 1;
    localparam int VTX_W     = 30;
    localparam int ROW_W     = VTX_W + 1;
    localparam int NSTEPS    = 2 * EXT_BITS;
    localparam int CNT_W     = 3;
    localparam int DIR_W     = 2;
    localparam int ADDR_W    = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    localparam logic [ADDR_W-1:0] REG_GRID_X = 2'd0;
    localparam logic [ADDR_W-1:0] REG_GRID_Y = 2'd1;
    localparam logic [ADDR_W-1:0] REG_GRID_Z = 2'd2;

    typedef logic [VTX_W-1:0]   t_vtx;
    typedef logic [ROW_W-1:0]   t_row;
    typedef logic [EXT_W-1:0]   t_ext;
    typedef logic [PLANE_W-1:0] t_plane;
    typedef logic [TOT_W-1:0]   t_tot;

    typedef enum logic [DIR_W-1:0] {
        DIR_SELF = 2'd0,
        DIR_XM   = 2'd1,
        DIR_YM   = 2'd2,
        DIR_ZM   = 2'd3
    } t_dir;

    // one division step stage: vertex, running remainder, y-neighbor flag
    typedef struct packed {
        logic vld;
        t_vtx vertex;
        t_vtx rem;
        logic jnz;
    } t_stage;

    function automatic t_ext clamp_ext(input t_ext raw);
        t_ext top;
        top = t_ext'(1) << EXT_BITS;
        if (raw == '0) begin
            return t_ext'(1);
        end else if (raw > top) begin
            return top;
        end
        return raw;
    endfunction

endpackage

`default_nettype wire

FILE: sv/stencil_sparsity_pattern_generator_unit.sv
// Top level of the seven-point stencil lower-triangle sparsity pattern generator.
//
// Slave stream: one request per vertex, tdata[29:0] is the zero-based linear index
// (x fastest, then y, then z). Master stream: one request per nonzero, in the order
// self, x-1, y-1, z-1; tlast marks the vertex's final entry, which also carries the
// entry count. tuser flags a vertex at or beyond nx*ny*nz (single entry, column 0).
// Config port: write grid_x/grid_y/grid_z (index 0/1/2) while the block is idle;
// zero reads as 1, values above 1024 saturate to 1024.
// Path: the first entry of a vertex passes an input register, 20 compare/subtract
// stages (10 for z, 10 for y/x), then the output register of the serializer.
// Throughput: the serializer drives one entry per cycle while the master is ready;
// a vertex yields 1 to 4 entries, and interior vertices yield 4, which sets the
// sustained rate.
// A stalled master holds the current entry; the pipeline freezes as a whole only
// when its last stage holds a vertex that the serializer cannot take yet.
// Reset clears all valid bits and sets the extents to 1.
`default_nettype none

module stencil_sparsity_pattern_generator_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [ssp_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  wire logic [ssp_pkg::EXT_W-1:0]          i_cfg_wdata,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [ssp_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,  // [29:0] vertex
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [30:0] row_index, [61:31] col_index, [63:62] direction, [66:64] entry_count
    output logic [ssp_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    output logic                                    o_m_axis_tuser   // [0] out_of_range
);

    ssp_pkg::t_ext   r_grid_x;
    ssp_pkg::t_ext   r_grid_y;
    ssp_pkg::t_ext   r_grid_z;
    ssp_pkg::t_ext   r_nx;
    ssp_pkg::t_ext   r_nz;
    ssp_pkg::t_plane r_plane;
    ssp_pkg::t_tot   r_total;

    logic            r_in_vld;
    ssp_pkg::t_vtx   r_in_vertex;
    logic            w_en;
    logic            w_emit_rdy;

    ssp_pkg::t_stage w_st [ssp_pkg::NSTEPS+1];

    ssp_pkg::t_row   w_row;
    ssp_pkg::t_row   w_col;
    ssp_pkg::t_dir   w_dir;
    logic [ssp_pkg::CNT_W-1:0] w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_x <= ssp_pkg::t_ext'(1);
            r_grid_y <= ssp_pkg::t_ext'(1);
            r_grid_z <= ssp_pkg::t_ext'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                ssp_pkg::REG_GRID_X: r_grid_x <= i_cfg_wdata;
                ssp_pkg::REG_GRID_Y: r_grid_y <= i_cfg_wdata;
                ssp_pkg::REG_GRID_Z: r_grid_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // derived extents: nx, nz and plane registered from the grid registers, total from plane and nz
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx    <= ssp_pkg::t_ext'(1);
            r_nz    <= ssp_pkg::t_ext'(1);
            r_plane <= ssp_pkg::t_plane'(1);
            r_total <= ssp_pkg::t_tot'(1);
        end else begin
            r_nx    <= ssp_pkg::clamp_ext(r_grid_x);
            r_nz    <= ssp_pkg::clamp_ext(r_grid_z);
            r_plane <= ssp_pkg::t_plane'(ssp_pkg::clamp_ext(r_grid_x))
                       * ssp_pkg::t_plane'(ssp_pkg::clamp_ext(r_grid_y));
            r_total <= ssp_pkg::t_tot'(r_plane) * ssp_pkg::t_tot'(r_nz);
        end
    end

    assign w_en            = !w_st[ssp_pkg::NSTEPS].vld || w_emit_rdy;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_vertex <= i_s_axis_tdata[ssp_pkg::VTX_W-1:0];
        end
    end

    assign w_st[0] = '{vld: r_in_vld, vertex: r_in_vertex, rem: r_in_vertex, jnz: 1'b0};

    // first half: remainder by the xy plane; second half: remainder by nx
    for (genvar s = 0; s < ssp_pkg::NSTEPS; s++) begin : g_step
        ssp_pkg::t_stage w_in;
        ssp_pkg::t_vtx   w_div;

        if (s < ssp_pkg::EXT_BITS) begin : g_plane
            assign w_in  = w_st[s];
            assign w_div = ssp_pkg::t_vtx'(r_plane) << (ssp_pkg::EXT_BITS - 1 - s);
        end else begin : g_x
            if (s == ssp_pkg::EXT_BITS) begin : g_jchk
                assign w_in = '{vld: w_st[s].vld, vertex: w_st[s].vertex,
                                rem: w_st[s].rem,
                                jnz: (w_st[s].rem >= ssp_pkg::t_vtx'(r_nx))};
            end else begin : g_pass
                assign w_in = w_st[s];
            end
            assign w_div = ssp_pkg::t_vtx'(r_nx) << (ssp_pkg::NSTEPS - 1 - s);
        end

        ssp_div_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_stage   (w_in),
            .i_divisor (w_div),
            .o_stage   (w_st[s+1])
        );
    end

    ssp_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_st[ssp_pkg::NSTEPS]),
        .i_nx     (r_nx),
        .i_plane  (r_plane),
        .i_total  (r_total),
        .o_rdy    (w_emit_rdy),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_row    (w_row),
        .o_col    (w_col),
        .o_dir    (w_dir),
        .o_cnt    (w_cnt),
        .o_last   (o_m_axis_tlast),
        .o_oor    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {5'b00000, w_cnt, w_dir, w_col, w_row};

endmodule

`default_nettype wire

FILE: sv/ssp_div_stage.sv
// One restoring remainder step of the coordinate split pipeline.
`default_nettype none

module ssp_div_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire ssp_pkg::t_stage i_stage,
    input  wire ssp_pkg::t_vtx   i_divisor,
    output ssp_pkg::t_stage      o_stage
);

    logic            r_vld;
    ssp_pkg::t_vtx   r_vertex;
    ssp_pkg::t_vtx   r_rem;
    logic            r_jnz;
    ssp_pkg::t_vtx   n_rem;

    always_comb begin
        if (i_stage.rem >= i_divisor) begin
            n_rem = i_stage.rem - i_divisor;
        end else begin
            n_rem = i_stage.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stage.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vertex <= i_stage.vertex;
            r_rem    <= n_rem;
            r_jnz    <= i_stage.jnz;
        end
    end

    assign o_stage = '{vld: r_vld, vertex: r_vertex, rem: r_rem, jnz: r_jnz};

endmodule

`default_nettype wire

FILE: sv/ssp_emit.sv
// Output serializer: turns one split vertex into its run of stencil entries.
`default_nettype none

module ssp_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ssp_pkg::t_stage i_stage,
    input  wire ssp_pkg::t_ext   i_nx,
    input  wire ssp_pkg::t_plane i_plane,
    input  wire ssp_pkg::t_tot   i_total,
    output logic                 o_rdy,
    output logic                 o_tvalid,
    input  wire logic            i_tready,
    output ssp_pkg::t_row        o_row,
    output ssp_pkg::t_row        o_col,
    output ssp_pkg::t_dir        o_dir,
    output logic [ssp_pkg::CNT_W-1:0] o_cnt,
    output logic                 o_last,
    output logic                 o_oor
);

    logic                      r_busy;
    logic [3:0]                r_mask;
    logic [ssp_pkg::CNT_W-1:0] r_cnt;
    logic                      r_oor;
    ssp_pkg::t_row             r_row;
    ssp_pkg::t_row             r_col [4];

    logic                      n_busy;
    logic [3:0]                n_mask;
    logic [3:0]                w_rest;
    ssp_pkg::t_dir             w_dir;
    logic                      w_last;
    logic                      w_load;
    logic                      w_oor;
    logic                      w_inz;
    logic                      w_knz;
    ssp_pkg::t_row             w_row;

    // lowest pending entry goes out first
    always_comb begin
        if (r_mask[0]) begin
            w_dir = ssp_pkg::DIR_SELF;
        end else if (r_mask[1]) begin
            w_dir = ssp_pkg::DIR_XM;
        end else if (r_mask[2]) begin
            w_dir = ssp_pkg::DIR_YM;
        end else begin
            w_dir = ssp_pkg::DIR_ZM;
        end
    end

    assign w_rest = r_mask & ~(4'b0001 << w_dir);
    assign w_last = (w_rest == 4'b0000);
    assign o_rdy  = !r_busy || (i_tready && w_last);
    assign w_load = i_stage.vld && o_rdy;

    assign w_oor = {1'b0, i_stage.vertex} >= i_total;
    assign w_inz = (i_stage.rem != '0);
    assign w_knz = i_stage.vertex >= ssp_pkg::t_vtx'(i_plane);
    assign w_row = ssp_pkg::t_row'(i_stage.vertex) + ssp_pkg::t_row'(1);

    always_comb begin
        n_busy = r_busy;
        n_mask = r_mask;
        if (w_load) begin
            n_busy = 1'b1;
            n_mask = w_oor ? 4'b0001 : {w_knz, i_stage.jnz, w_inz, 1'b1};
        end else if (r_busy && i_tready) begin
            n_busy = !w_last;
            n_mask = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mask <= 4'b0000;
        end else begin
            r_busy <= n_busy;
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oor    <= w_oor;
            r_row    <= w_row;
            r_cnt    <= w_oor ? '0 :
                        ssp_pkg::CNT_W'(1) + ssp_pkg::CNT_W'(w_inz)
                        + ssp_pkg::CNT_W'(i_stage.jnz) + ssp_pkg::CNT_W'(w_knz);
            r_col[0] <= w_oor ? '0 : w_row;
            r_col[1] <= ssp_pkg::t_row'(i_stage.vertex);
            r_col[2] <= w_row - ssp_pkg::t_row'(i_nx);
            r_col[3] <= w_row - ssp_pkg::t_row'(i_plane);
        end
    end

    assign o_tvalid = r_busy;
    assign o_row    = r_row;
    assign o_col    = r_col[w_dir];
    assign o_dir    = w_dir;
    assign o_cnt    = w_last ? r_cnt : '0;
    assign o_last   = w_last;
    assign o_oor    = r_oor;

endmodule

`default_nettype wire
